/* hdl/quote_aware_bracket_checker_assert.svh */
// Assertion macros shared by the bracket checker RTL.
`ifndef QUOTE_AWARE_BRACKET_CHECKER_ASSERT_SVH
`define QUOTE_AWARE_BRACKET_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QABC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QABC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket checker assertion failed");

`endif

/* hdl/qabc_pkg.sv */
// Shared types and constants for the quote-aware bracket checker.
`default_nettype none

package qabc_pkg;

    // Depth of the queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Character class decided by the front end.
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_SQUOTE,
        CLS_DQUOTE
    } t_class;

    // Bracket kind as stored on the stack.
    typedef enum logic [1:0] {
        KIND_ROUND,
        KIND_SQUARE,
        KIND_CURLY,
        KIND_NONE
    } t_kind;

    // Sticky error codes.
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_MISMATCH,
        ERR_UNMATCHED,
        ERR_OVERFLOW
    } t_err;

    // One classified request travelling from front to back.
    typedef struct packed {
        t_class cls;
        t_kind  kind;
        logic   last;
    } t_item;

    // Status the back end reports for checking.
    typedef struct packed {
        logic fire;
        logic last;
        logic clear;
        t_err err;
    } t_back_stat;

endpackage

`default_nettype wire

/* hdl/qabc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module qabc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/qabc_front.sv */
// Front end: accepts text bytes and classifies them into bracket and quote classes.
`default_nettype none

module qabc_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [7:0]     i_text_byte,
    input  wire logic           i_is_last,
    output logic                o_item_valid,
    output qabc_pkg::t_item     o_item,
    input  wire logic           i_item_ready
);
    import qabc_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Decode the byte into its class and bracket kind.
    always_comb begin
        n_item.last = i_is_last;
        n_item.cls  = CLS_OTHER;
        n_item.kind = KIND_NONE;
        case (i_text_byte)
            8'h28: begin n_item.cls = CLS_OPEN;  n_item.kind = KIND_ROUND;  end
            8'h5B: begin n_item.cls = CLS_OPEN;  n_item.kind = KIND_SQUARE; end
            8'h7B: begin n_item.cls = CLS_OPEN;  n_item.kind = KIND_CURLY;  end
            8'h29: begin n_item.cls = CLS_CLOSE; n_item.kind = KIND_ROUND;  end
            8'h5D: begin n_item.cls = CLS_CLOSE; n_item.kind = KIND_SQUARE; end
            8'h7D: begin n_item.cls = CLS_CLOSE; n_item.kind = KIND_CURLY;  end
            8'h27: begin n_item.cls = CLS_SQUOTE; end
            8'h22: begin n_item.cls = CLS_DQUOTE; end
            default: begin n_item.cls = CLS_OTHER; end
        endcase
    end

    // The stage takes a new request whenever it is empty or its content moves on.
    assign o_ready = !r_valid || i_item_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

/* hdl/qabc_fifo.sv */
// Short queue that decouples the classifier from the stack engine.
`default_nettype none

module qabc_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire qabc_pkg::t_item i_item,
    output logic                o_pop_valid,
    output qabc_pkg::t_item     o_item,
    input  wire logic           i_pop_ready
);
    import qabc_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_item       = r_mem[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/qabc_back.sv */
// Back end: quote tracking, bracket stack and registered result stage.
`default_nettype none

module qabc_back #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_item_valid,
    output logic                    o_item_ready,
    input  wire qabc_pkg::t_item    i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_error_code,
    output logic [6:0]              o_nesting_depth,
    output logic                    o_balanced,
    output logic                    o_string_done,
    output qabc_pkg::t_back_stat    o_stat
);
    import qabc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Architectural state; r_top mirrors the stack entry at r_cnt - 1.
    logic [CW-1:0]  r_cnt;
    t_kind          r_top;
    logic           r_sq;
    logic           r_dq;
    t_err           r_err;

    // Result register.
    logic           r_out_valid;
    t_err           r_out_err;
    logic [6:0]     r_out_depth;
    logic           r_out_bal;
    logic           r_out_done;

    // State after this request, before the end-of-string clear.
    logic [CW-1:0]  u_cnt;
    t_kind          u_top;
    logic           u_sq;
    logic           u_dq;
    t_err           u_err;

    logic [CW-1:0]  n_cnt;
    logic           n_sq;
    logic           n_dq;
    t_err           n_err;

    logic           fire;
    logic           we;
    logic [CW-1:0]  rd_ptr;
    logic [1:0]     below_top;
    logic [CW+6:0]  depth_ext;

    // The entry below the top is prefetched every cycle from the next count.
    qabc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_item.kind),
        .i_raddr (rd_ptr[AW-1:0]),
        .o_rdata (below_top)
    );

    assign o_item_ready = !r_out_valid || i_ready;
    assign fire         = i_item_valid && o_item_ready;

    // Stack and quote update for one request.
    always_comb begin
        u_cnt = r_cnt;
        u_top = r_top;
        u_sq  = r_sq;
        u_dq  = r_dq;
        u_err = r_err;
        we    = 1'b0;
        if (fire) begin
            if (!(r_sq || r_dq) && r_err == ERR_NONE) begin
                case (i_item.cls)
                    CLS_OPEN: begin
                        if (r_cnt >= CW'(STACK_DEPTH)) begin
                            u_err = ERR_OVERFLOW;
                        end else begin
                            we    = 1'b1;
                            u_cnt = r_cnt + CW'(1);
                            u_top = i_item.kind;
                        end
                    end
                    CLS_CLOSE: begin
                        if (r_cnt == '0) begin
                            u_err = ERR_UNMATCHED;
                        end else if (r_top != i_item.kind) begin
                            u_err = ERR_MISMATCH;
                        end else begin
                            u_cnt = r_cnt - CW'(1);
                            u_top = t_kind'(below_top);
                        end
                    end
                    default: begin
                        u_cnt = r_cnt;
                    end
                endcase
            end
            if (i_item.cls == CLS_SQUOTE && !r_dq) begin
                u_sq = !r_sq;
            end
            if (i_item.cls == CLS_DQUOTE && !r_sq) begin
                u_dq = !r_dq;
            end
        end
    end

    // End of string returns everything to its reset values.
    always_comb begin
        if (fire && i_item.last) begin
            n_cnt = '0;
            n_sq  = 1'b0;
            n_dq  = 1'b0;
            n_err = ERR_NONE;
        end else begin
            n_cnt = u_cnt;
            n_sq  = u_sq;
            n_dq  = u_dq;
            n_err = u_err;
        end
    end

    assign rd_ptr    = n_cnt - CW'(2);
    assign depth_ext = (CW + 7)'(u_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sq  <= 1'b0;
            r_dq  <= 1'b0;
            r_err <= ERR_NONE;
        end else begin
            r_cnt <= n_cnt;
            r_sq  <= n_sq;
            r_dq  <= n_dq;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= u_top;
    end

    // Result register: loads on every processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_item_ready) begin
            r_out_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_err   <= u_err;
            r_out_depth <= depth_ext[6:0];
            r_out_bal   <= i_item.last && (u_err == ERR_NONE) && (u_cnt == '0);
            r_out_done  <= i_item.last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_error_code    = r_out_err;
    assign o_nesting_depth = r_out_depth;
    assign o_balanced      = r_out_bal;
    assign o_string_done   = r_out_done;

    assign o_stat.fire  = fire;
    assign o_stat.last  = i_item.last;
    assign o_stat.clear = (r_cnt == '0) && !r_sq && !r_dq && (r_err == ERR_NONE);
    assign o_stat.err   = r_err;

endmodule

`default_nettype wire

/* hdl/quote_aware_bracket_checker.sv */
// Top level of the quote-aware bracket checker: front end, queue and stack engine.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_text_byte, i_is_last
//   result    out        o_valid / i_ready   o_error_code, o_nesting_depth,
//                                            o_balanced, o_string_done
//
// One byte per cycle sustained while results are taken. A result follows its
// byte through the classifier register, a queue entry and the result register.
// The rate is set by the stack engine: the top entry sits in a register and
// the entry below it is prefetched from the stack RAM's registered read port.
// Reset clears the stack count, quote flags, error status and all valid bits;
// no clearing pass is needed. A stalled result stalls only the stack engine,
// and the queue and classifier keep taking bytes until they fill.
`default_nettype none

module quote_aware_bracket_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_error_code,
    output logic [6:0]      o_nesting_depth,
    output logic            o_balanced,
    output logic            o_string_done
);
    import qabc_pkg::*;

    logic       front_valid;
    t_item      front_item;
    logic       front_ready;
    logic       q_valid;
    t_item      q_item;
    logic       q_ready;
    t_back_stat stat;

    // Byte classification.
    qabc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_text_byte  (i_text_byte),
        .i_is_last    (i_is_last),
        .o_item_valid (front_valid),
        .o_item       (front_item),
        .i_item_ready (front_ready)
    );

    // Decoupling queue.
    qabc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_item       (front_item),
        .o_pop_valid  (q_valid),
        .o_item       (q_item),
        .i_pop_ready  (q_ready)
    );

    // Stack engine and result register.
    qabc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item_valid    (q_valid),
        .o_item_ready    (q_ready),
        .i_item          (q_item),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_error_code    (o_error_code),
        .o_nesting_depth (o_nesting_depth),
        .o_balanced      (o_balanced),
        .o_string_done   (o_string_done),
        .o_stat          (stat)
    );

    // A balanced verdict only closes a string with no error and an empty stack.
    `include "quote_aware_bracket_checker_assert.svh"
    `QABC_ASSERT_NOW(a_balanced_clean, i_clk, i_rst_n, o_valid && o_balanced,
        o_string_done && o_error_code == ERR_NONE && o_nesting_depth == 7'd0)

    // An error stays until the string ends.
    `QABC_ASSERT_NEXT(a_error_sticky, i_clk, i_rst_n,
        stat.err != ERR_NONE && !(stat.fire && stat.last), stat.err == $past(stat.err))

    // After the last byte all string state is back at its reset values.
    `QABC_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, stat.fire && stat.last, stat.clear)

endmodule

`default_nettype wire
